[src/qbn_pkg.sv]
`default_nettype none

package qbn_pkg;

  // Storage limits of the coefficient tables and of the position counters.
  localparam int unsigned MaxChannels = 64;
  localparam int unsigned MaxPlane    = 1048576;
  localparam int unsigned ChW         = $clog2(MaxChannels);
  localparam int unsigned PlW         = $clog2(MaxPlane);

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Item kinds.
  localparam logic ActLoad = 1'b0;
  localparam logic ActData = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgLayout    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCaffe     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChanCount = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPlaneSize = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInZero    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOutZero   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgInScale   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgOutRecip  = 3'd7;

  typedef struct packed {
    logic               action;
    logic [5:0]         channel_index;
    logic signed [31:0] mean_term;
    logic signed [31:0] var_inv_term;
    logic signed [31:0] gamma_term;
    logic signed [31:0] beta_term;
    logic [7:0]         pixel;
    logic               first_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic [5:0] channel_used;
  } out_item_t;

  typedef struct packed {
    logic        layout_mode;
    logic        caffe_mode;
    logic [6:0]  channel_count;
    logic [20:0] plane_size;
    logic [7:0]  input_zero;
    logic [7:0]  output_zero;
    logic [31:0] input_scale;
    logic [31:0] output_scale_recip;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] mean_term;
    logic signed [31:0] var_inv_term;
    logic signed [31:0] gamma_term;
    logic signed [31:0] beta_term;
  } coef_t;

  // One queued word: a coefficient load or a data byte with its channel.
  typedef struct packed {
    logic           action;
    logic [ChW-1:0] chan;
    logic [7:0]     pixel;
    coef_t          coef;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GM,
    ST_GV,
    ST_S2,
    ST_Y,
    ST_ABS,
    ST_HI,
    ST_LO,
    ST_RND,
    ST_DONE
  } back_st_e;

endpackage

`default_nettype wire

[src/qbn_front.sv]
`default_nettype none

module qbn_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire qbn_pkg::in_item_t in_data_i,
  input  wire qbn_pkg::cfg_t     cfg_i,
  input  wire qbn_pkg::q_stat_t  q_stat_i,
  output logic                  push_o,
  output qbn_pkg::q_entry_t     push_data_o
);
  import qbn_pkg::*;

  logic [ChW-1:0] ch_cnt_q, ch_cnt_d;
  logic [PlW-1:0] pl_cnt_q, pl_cnt_d;
  logic [ChW:0]   ch_lim;
  logic [PlW:0]   pl_lim;
  logic [ChW-1:0] ch_cur, ch_adv;
  logic [PlW-1:0] pl_cur, pl_adv;
  logic           accept, is_data;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign is_data    = (in_data_i.action == ActData);

  // Clamp the limits into their legal ranges.
  always_comb begin
    if (cfg_i.channel_count == '0) begin
      ch_lim = (ChW+1)'(1);
    end else if (cfg_i.channel_count > 7'(MaxChannels)) begin
      ch_lim = (ChW+1)'(MaxChannels);
    end else begin
      ch_lim = (ChW+1)'(cfg_i.channel_count);
    end
    if (cfg_i.plane_size == '0) begin
      pl_lim = (PlW+1)'(1);
    end else if (cfg_i.plane_size > 21'(MaxPlane)) begin
      pl_lim = (PlW+1)'(MaxPlane);
    end else begin
      pl_lim = (PlW+1)'(cfg_i.plane_size);
    end
  end

  // A start-of-image byte restarts both counters before use.
  assign ch_cur = in_data_i.first_of_image ? '0 : ch_cnt_q;
  assign pl_cur = in_data_i.first_of_image ? '0 : pl_cnt_q;

  assign ch_adv = (({1'b0, ch_cur} + 1'b1) >= ch_lim) ? '0 : ch_cur + 1'b1;
  assign pl_adv = (({1'b0, pl_cur} + 1'b1) >= pl_lim) ? '0 : pl_cur + 1'b1;

  always_comb begin
    ch_cnt_d = ch_cnt_q;
    pl_cnt_d = pl_cnt_q;
    if (accept && is_data) begin
      if (!cfg_i.layout_mode) begin
        pl_cnt_d = pl_adv;
        ch_cnt_d = (pl_adv == '0) ? ch_adv : ch_cur;
      end else begin
        ch_cnt_d = ch_adv;
        pl_cnt_d = (ch_adv == '0) ? pl_adv : pl_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_cnt_q <= '0;
      pl_cnt_q <= '0;
    end else begin
      ch_cnt_q <= ch_cnt_d;
      pl_cnt_q <= pl_cnt_d;
    end
  end

  assign push_o                        = accept;
  assign push_data_o.action            = in_data_i.action;
  assign push_data_o.chan              = is_data ? ch_cur : in_data_i.channel_index;
  assign push_data_o.pixel             = in_data_i.pixel;
  assign push_data_o.coef.mean_term    = in_data_i.mean_term;
  assign push_data_o.coef.var_inv_term = in_data_i.var_inv_term;
  assign push_data_o.coef.gamma_term   = in_data_i.gamma_term;
  assign push_data_o.coef.beta_term    = in_data_i.beta_term;

endmodule

`default_nettype wire

[src/qbn_fifo.sv]
`default_nettype none

module qbn_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire qbn_pkg::q_entry_t push_data_i,
  input  wire logic              pop_i,
  output qbn_pkg::q_entry_t      head_o,
  output qbn_pkg::q_stat_t       stat_o
);
  import qbn_pkg::*;

  q_entry_t         slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

[src/qbn_back.sv]
`default_nettype none

module qbn_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qbn_pkg::cfg_t     cfg_i,
  input  wire qbn_pkg::q_stat_t  q_stat_i,
  input  wire qbn_pkg::q_entry_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output qbn_pkg::out_item_t     out_data_o
);
  import qbn_pkg::*;

  back_st_e state_q, state_d;

  // Coefficient tables, one word per channel.
  coef_t mem_q [MaxChannels];
  coef_t rd_q;

  logic signed [64:0] prod_q;
  logic signed [33:0] x16_q;
  logic signed [31:0] s1_q, s2_q;
  logic [62:0]        m_q;
  logic               neg_q;
  logic [62:0]        t_q;
  logic [8:0]         rsat_q;
  logic [ChW-1:0]     ch_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic               mem_we, rd_en, out_load;

  // Shared multiplier.
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty && head_i.action == ActData) begin
          state_d = ST_GM;
        end
      end
      ST_GM:   state_d = ST_GV;
      ST_GV:   state_d = ST_S2;
      ST_S2:   state_d = ST_Y;
      ST_Y:    state_d = ST_ABS;
      ST_ABS:  state_d = ST_HI;
      ST_HI:   state_d = ST_LO;
      ST_LO:   state_d = ST_RND;
      ST_RND:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      ST_IDLE: begin
        pop_o  = !q_stat_i.empty;
        mem_we = !q_stat_i.empty && head_i.action == ActLoad;
        rd_en  = !q_stat_i.empty && head_i.action == ActData;
        mul_a  = 34'(signed'({1'b0, head_i.pixel} - {1'b0, cfg_i.input_zero}));
        mul_b  = {2'b00, cfg_i.input_scale};
      end
      ST_GM: begin
        mul_a = 34'(rd_q.gamma_term);
        mul_b = 34'(rd_q.mean_term);
      end
      ST_GV: begin
        mul_a = 34'(rd_q.gamma_term);
        mul_b = 34'(rd_q.var_inv_term);
      end
      ST_Y: begin
        mul_a = x16_q;
        mul_b = 34'(s2_q);
      end
      ST_HI: begin
        mul_a = {3'b000, m_q[62:32]};
        mul_b = {2'b00, cfg_i.output_scale_recip};
      end
      ST_LO: begin
        mul_a = {2'b00, m_q[31:0]};
        mul_b = {2'b00, cfg_i.output_scale_recip};
      end
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Round x by 2^8, half away from zero.
  logic        x_neg;
  logic [40:0] x_mag, x_sum;
  logic [32:0] x_r;
  logic signed [33:0] x16_d;

  assign x_neg = prod_q[40];
  assign x_mag = x_neg ? 41'(-prod_q[40:0]) : prod_q[40:0];
  assign x_sum = x_mag + 41'd128;
  assign x_r   = x_sum[40:8];
  assign x16_d = x_neg ? -signed'({1'b0, x_r}) : signed'({1'b0, x_r});

  // Round a coefficient product by 2^16, half away from zero.
  logic        p_neg;
  logic [63:0] p_mag, p_sum;
  logic [46:0] p_r;
  logic signed [47:0] p_rs;
  logic signed [48:0] s1_wide, s2_wide;
  logic signed [31:0] s1_d, s2_d;

  assign p_neg   = prod_q[63];
  assign p_mag   = p_neg ? 64'(-prod_q[63:0]) : prod_q[63:0];
  assign p_sum   = p_mag + 64'd32768;
  assign p_r     = p_sum[62:16];
  assign p_rs    = p_neg ? -signed'({1'b0, p_r}) : signed'({1'b0, p_r});
  assign s1_wide = 49'(p_rs) + 49'(rd_q.beta_term);
  assign s2_wide = 49'(p_rs);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign s1_d = cfg_i.caffe_mode ? rd_q.mean_term    : sat32(s1_wide);
  assign s2_d = cfg_i.caffe_mode ? rd_q.var_inv_term : sat32(s2_wide);

  // Add the shifted offset and take the magnitude.
  logic signed [64:0] y;
  logic [64:0]        y_mag;

  assign y     = prod_q + {{17{s1_q[31]}}, s1_q, 16'h0000};
  assign y_mag = y[64] ? 65'(-y) : y;

  // Requantize: round(m * recip / 2^48), then limit to nine bits.
  logic [94:0] full;
  logic [46:0] r_all;
  logic [8:0]  rsat_d;

  assign full   = {t_q, 32'h0} + {31'h0, prod_q[63:0]} + (95'd1 << 47);
  assign r_all  = full[94:48];
  assign rsat_d = (|r_all[46:9]) ? 9'h1ff : r_all[8:0];

  // Apply the zero point and clamp to a byte.
  logic signed [10:0] res;
  logic [7:0]         res_byte;

  assign res = neg_q ? signed'({3'b000, cfg_i.output_zero} - {2'b00, rsat_q})
                     : signed'({3'b000, cfg_i.output_zero} + {2'b00, rsat_q});
  always_comb begin
    if (res[10]) begin
      res_byte = 8'h00;
    end else if (res > 11'sd255) begin
      res_byte = 8'hff;
    end else begin
      res_byte = res[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_i.chan] <= head_i.coef;
    end
    if (rd_en) begin
      rd_q <= mem_q[head_i.chan];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        prod_q <= mul_p[64:0];
        ch_q   <= head_i.chan;
      end
      ST_GM: begin
        x16_q  <= x16_d;
        prod_q <= mul_p[64:0];
      end
      ST_GV: begin
        s1_q   <= s1_d;
        prod_q <= mul_p[64:0];
      end
      ST_S2:  s2_q <= s2_d;
      ST_Y:   prod_q <= mul_p[64:0];
      ST_ABS: begin
        m_q   <= y_mag[62:0];
        neg_q <= y[64];
      end
      ST_HI:  prod_q <= mul_p[64:0];
      ST_LO: begin
        t_q    <= prod_q[62:0];
        prod_q <= mul_p[64:0];
      end
      ST_RND: rsat_q <= rsat_d;
      default: ;
    endcase
    if (out_load) begin
      out_data_q.result_value <= res_byte;
      out_data_q.channel_used <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[src/quantized_batchnorm_uint8.sv]
`default_nettype none

// Quantized per-channel batch normalization on a stream of uint8 words.
// A load word (action 0) stores one channel's mean, inverse-variance,
// gamma and beta coefficients and yields no result; a data word (action 1)
// yields one result byte plus the channel whose coefficients were applied.
// The channel is tracked by position counters that follow the NCHW or NHWC
// layout; first_of_image on a data word restarts them at that word.
// The front accepts one word per cycle, unless the four-deep queue is full,
// and assigns the channel as it goes; the back drains the queue in order.
// The back takes a load word while idle; a data word steps it through
// states in which the single shared 34x34 multiplier forms six products,
// plus the rounding and requantization steps. Results leave through an
// output register, so the back keeps working while a finished result
// waits on out_stall_i. Configuration writes are registered and must only
// be issued while the block is idle. Coefficient entries read before they
// are written give undefined results.
module quantized_batchnorm_uint8 (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire qbn_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output qbn_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i
);
  import qbn_pkg::*;

  cfg_t     cfg_q;
  q_stat_t  q_stat;
  q_entry_t push_data, head;
  logic     push, pop;

  // Register file: each write replaces one register, masked to its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout_mode        <= 1'b0;
      cfg_q.caffe_mode         <= 1'b0;
      cfg_q.channel_count      <= 7'd1;
      cfg_q.plane_size         <= 21'd1;
      cfg_q.input_zero         <= 8'd0;
      cfg_q.output_zero        <= 8'd0;
      cfg_q.input_scale        <= 32'h0100_0000;
      cfg_q.output_scale_recip <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLayout:    cfg_q.layout_mode        <= cfg_wdata_i[0];
        CfgCaffe:     cfg_q.caffe_mode         <= cfg_wdata_i[0];
        CfgChanCount: cfg_q.channel_count      <= cfg_wdata_i[6:0];
        CfgPlaneSize: cfg_q.plane_size         <= cfg_wdata_i[20:0];
        CfgInZero:    cfg_q.input_zero         <= cfg_wdata_i[7:0];
        CfgOutZero:   cfg_q.output_zero        <= cfg_wdata_i[7:0];
        CfgInScale:   cfg_q.input_scale        <= cfg_wdata_i;
        CfgOutRecip:  cfg_q.output_scale_recip <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: accept words, assign the channel, enqueue.
  qbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: decouple the front from the multi-cycle back.
  qbn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // Back: store coefficients, normalize and requantize data words.
  qbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[src/qbn_checker.sv]
`default_nettype none

module qbn_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire qbn_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire qbn_pkg::out_item_t out_data_o
);
  import qbn_pkg::*;

  // Count data words accepted but not yet delivered.
  logic [3:0] pend_q;
  logic       in_data_acc, out_acc;

  assign in_data_acc = in_valid_i && !in_stall_o && in_data_i.action == ActData;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_data_acc) - 4'(out_acc);
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result word without a pending data word");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(QDepth + 2))
    else $error("more data words in flight than the block can hold");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result word changed");

endmodule

bind quantized_batchnorm_uint8 qbn_checker u_qbn_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import qbn_pkg::*;

  // Idle draw per word, the long receiver hold-off, the pause that lets
  // queued load words drain, and the watchdog's quiet-cycle limit.
  localparam int unsigned MaxGap      = 13;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned PhaseWords  = 100;
  localparam int unsigned RandPhases  = 10;

  // Spread of well-formed coefficients: offsets up to +-64.0, scales +-2.0.
  localparam int unsigned MeanSpan  = 1 << 22;
  localparam int unsigned ScaleSpan = 1 << 17;

  // Tracks the coefficient tables, the position counters and the register
  // file, and works out the output byte that every data word must produce.
  class bn_tracker;
    cfg_t               regs;
    logic signed [31:0] mean_tab  [MaxChannels];
    logic signed [31:0] var_tab   [MaxChannels];
    logic signed [31:0] gamma_tab [MaxChannels];
    logic signed [31:0] beta_tab  [MaxChannels];
    int unsigned        chan_pos;
    int unsigned        plane_pos;
    out_item_t          due_bytes [$];
    int unsigned        errors;

    function new();
      regs                    = '0;
      regs.channel_count      = 7'd1;
      regs.plane_size         = 21'd1;
      regs.input_scale        = 32'h0100_0000;
      regs.output_scale_recip = 32'h0001_0000;
      chan_pos                = 0;
      plane_pos               = 0;
      errors                  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CfgLayout:    regs.layout_mode        = data[0];
        CfgCaffe:     regs.caffe_mode         = data[0];
        CfgChanCount: regs.channel_count      = data[6:0];
        CfgPlaneSize: regs.plane_size         = data[20:0];
        CfgInZero:    regs.input_zero         = data[7:0];
        CfgOutZero:   regs.output_zero        = data[7:0];
        CfgInScale:   regs.input_scale        = data;
        CfgOutRecip:  regs.output_scale_recip = data;
        default: ;
      endcase
    endfunction

    // Shift right by sh, rounding half away from zero.
    static function longint round_away(longint v, int unsigned sh);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function int unsigned step_pos(int unsigned cnt, int unsigned lim);
      return (cnt + 1 >= lim) ? 0 : cnt + 1;
    endfunction

    function out_item_t normalize_byte(in_item_t w);
      int unsigned  ch_lim;
      int unsigned  pl_lim;
      int unsigned  ch;
      longint       g;
      longint       s1;
      longint       s2;
      longint       x16;
      longint       y;
      longint       v;
      logic [63:0]  mag;
      logic [127:0] prod;
      out_item_t    o;
      ch_lim = regs.channel_count;
      if (ch_lim < 1) ch_lim = 1;
      if (ch_lim > MaxChannels) ch_lim = MaxChannels;
      pl_lim = regs.plane_size;
      if (pl_lim < 1) pl_lim = 1;
      if (pl_lim > MaxPlane) pl_lim = MaxPlane;

      if (w.first_of_image) begin
        chan_pos  = 0;
        plane_pos = 0;
      end
      ch = chan_pos;

      if (regs.caffe_mode) begin
        s1 = mean_tab[ch];
        s2 = var_tab[ch];
      end else begin
        g  = gamma_tab[ch];
        s1 = sat32(longint'(beta_tab[ch]) + round_away(g * mean_tab[ch], 16));
        s2 = sat32(round_away(g * var_tab[ch], 16));
      end

      // Dequantize to Q16.16, apply the channel, requantize from Q32.32.
      x16 = round_away((longint'(w.pixel) - longint'(regs.input_zero)) *
                       longint'(regs.input_scale), 8);
      y    = x16 * s2 + s1 * 65536;
      mag  = (y < 0) ? -y : y;
      prod = mag * regs.output_scale_recip;
      prod = (prod + (128'd1 << 47)) >> 48;
      v    = longint'(prod[63:0]);
      if (y < 0) v = -v;
      v = v + longint'(regs.output_zero);
      if (v > 255) v = 255;
      if (v < 0) v = 0;
      o.result_value = v[7:0];
      o.channel_used = ch[5:0];

      if (regs.layout_mode == 1'b0) begin
        plane_pos = step_pos(plane_pos, pl_lim);
        if (plane_pos == 0) chan_pos = step_pos(chan_pos, ch_lim);
      end else begin
        chan_pos = step_pos(chan_pos, ch_lim);
        if (chan_pos == 0) plane_pos = step_pos(plane_pos, pl_lim);
      end
      return o;
    endfunction

    function void take_word(in_item_t w);
      if (w.action == ActLoad) begin
        mean_tab[w.channel_index]  = w.mean_term;
        var_tab[w.channel_index]   = w.var_inv_term;
        gamma_tab[w.channel_index] = w.gamma_term;
        beta_tab[w.channel_index]  = w.beta_term;
      end else begin
        due_bytes.push_back(normalize_byte(w));
      end
    endfunction

    function void match_byte(out_item_t got);
      out_item_t want;
      if (due_bytes.size() == 0) begin
        $error("result_value: expected nothing, actual %0d", got.result_value);
        errors++;
        return;
      end
      want = due_bytes.pop_front();
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, actual %0d",
               want.result_value, got.result_value);
        errors++;
      end
      if (got.channel_used !== want.channel_used) begin
        $error("channel_used: expected %0d, actual %0d",
               want.channel_used, got.channel_used);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0]        cfg_wdata_i;

  // calm: both sides send and take with no idle cycles for a phase.
  // hold_req: ask the receiver for one long hold-off.
  bit        calm;
  bit        hold_req;
  bn_tracker trk = new();

  quantized_batchnorm_uint8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Mostly modest Q16.16 values around zero, now and then any 32-bit pattern.
  function automatic logic signed [31:0] pick_coef(int unsigned span);
    if ($urandom_range(0, 5) == 0) return $urandom;
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Offer one word after a random idle stretch; hold it until accepted.
  // Predict at the falling edge before the accepting rising edge.
  task automatic send_word(in_item_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(negedge clk_i); while (in_stall_o);
    trk.take_word(w);
    @(posedge clk_i);
  endtask

  // Load word: fill the unused fields with noise so every bit toggles.
  task automatic send_load(int unsigned ch, logic signed [31:0] m,
                           logic signed [31:0] v, logic signed [31:0] g,
                           logic signed [31:0] b);
    in_item_t w;
    w                = $urandom;
    w.action         = ActLoad;
    w.channel_index  = ch[5:0];
    w.mean_term      = m;
    w.var_inv_term   = v;
    w.gamma_term     = g;
    w.beta_term      = b;
    w.pixel          = $urandom;
    w.first_of_image = $urandom;
    send_word(w);
  endtask

  // Data word: coefficient fields and channel index carry noise only.
  task automatic send_data(logic [7:0] pix, logic first);
    in_item_t w;
    w.action         = ActData;
    w.channel_index  = $urandom;
    w.mean_term      = $urandom;
    w.var_inv_term   = $urandom;
    w.gamma_term     = $urandom;
    w.beta_term      = $urandom;
    w.pixel          = pix;
    w.first_of_image = first;
    send_word(w);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    trk.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Write the whole register file; only called while the block is idle.
  task automatic program_regs(cfg_t c);
    write_reg(CfgLayout,    {31'd0, c.layout_mode});
    write_reg(CfgCaffe,     {31'd0, c.caffe_mode});
    write_reg(CfgChanCount, {25'd0, c.channel_count});
    write_reg(CfgPlaneSize, {11'd0, c.plane_size});
    write_reg(CfgInZero,    {24'd0, c.input_zero});
    write_reg(CfgOutZero,   {24'd0, c.output_zero});
    write_reg(CfgInScale,   c.input_scale);
    write_reg(CfgOutRecip,  c.output_scale_recip);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every expected byte, then let queued loads drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (trk.due_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Result side: stall for a random stretch per word, then take one word.
  initial begin : result_side
    int unsigned gap;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        // Long hold-off so the queue fills and the input stalls.
        hold_req = 1'b0;
        gap      = HoldCycles;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (!out_valid_o);
      trk.match_byte(out_data_o);
      @(posedge clk_i);
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgLayout;
    cfg_wdata_i <= '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed setup: NCHW, caffe, three channels of two bytes each,
    // zero points mid-scale, unit scales.
    c                    = '0;
    c.caffe_mode         = 1'b1;
    c.channel_count      = 7'd3;
    c.plane_size         = 21'd2;
    c.input_zero         = 8'd128;
    c.output_zero        = 8'd128;
    c.input_scale        = 32'h0100_0000;
    c.output_scale_recip = 32'h0001_0000;
    program_regs(c);

    // Fill every table entry so no channel is ever read unwritten.
    for (int ch = 0; ch < MaxChannels; ch++) begin
      send_load(ch, pick_coef(MeanSpan), pick_coef(ScaleSpan),
                pick_coef(ScaleSpan), pick_coef(MeanSpan));
    end

    // Coefficient extremes on channels 0 and 1, an identity on 63,
    // a plain offset and a negative gamma on channel 2.
    send_load(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_load(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_load(63, 32'sh0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
    send_load(2, 32'sh0005_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0003_0000);

    // Walk the planes: channel 0, 1, 2 twice each, then wrap to 0.
    send_data(8'd0,   1'b1);
    send_data(8'd255, 1'b0);
    send_data(8'd128, 1'b0);
    send_data(8'd0,   1'b0);
    send_data(8'd255, 1'b0);
    send_data(8'd127, 1'b0);
    send_data(8'd129, 1'b0);
    send_data(8'd255, 1'b1);
    settle();

    // Same tables with gamma and beta folded in: saturating folds on 0 and 1.
    c.caffe_mode = 1'b0;
    program_regs(c);
    send_data(8'd255, 1'b1);
    send_data(8'd0,   1'b0);
    send_data(8'd200, 1'b0);
    send_data(8'd17,  1'b0);
    send_data(8'd128, 1'b0);
    send_data(8'd64,  1'b0);
    settle();

    for (int phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        0: begin
          c                    = '0;
          c.channel_count      = 7'd4;
          c.plane_size         = 21'd3;
          c.input_scale        = 32'h0100_0000;
          c.output_scale_recip = 32'h0001_0000;
        end
        1: begin
          // Channel count at the table limit, zero points and scales at their top values, a plane of one, NHWC, caffe.
          c.layout_mode        = 1'b1;
          c.caffe_mode         = 1'b1;
          c.channel_count      = 7'd64;
          c.plane_size         = 21'd1;
          c.input_zero         = 8'd255;
          c.output_zero        = 8'd255;
          c.input_scale        = 32'hFFFF_FFFF;
          c.output_scale_recip = 32'hFFFF_FFFF;
        end
        2: begin
          // Zero counts clamp to one; zero reciprocal yields output_zero.
          c.layout_mode        = 1'b1;
          c.caffe_mode         = 1'b0;
          c.channel_count      = 7'd0;
          c.plane_size         = 21'd0;
          c.input_zero         = 8'd7;
          c.output_zero        = 8'd100;
          c.input_scale        = 32'd0;
          c.output_scale_recip = 32'd0;
        end
        3: begin
          // Counts above the table and plane limits clamp.
          c.layout_mode        = 1'b0;
          c.caffe_mode         = 1'b1;
          c.channel_count      = 7'd127;
          c.plane_size         = 21'h1F_FFFF;
          c.input_zero         = 8'd128;
          c.output_zero        = 8'd0;
          c.input_scale        = 32'h0100_0000;
          c.output_scale_recip = 32'h0001_0000;
        end
        default: begin
          c.layout_mode        = $urandom;
          c.caffe_mode         = $urandom;
          c.channel_count      = $urandom_range(1, 8);
          c.plane_size         = $urandom_range(1, 5);
          c.input_zero         = $urandom;
          c.output_zero        = $urandom;
          c.input_scale        = $urandom_range(32'h0040_0000, 32'h0400_0000);
          c.output_scale_recip = $urandom_range(32'h0000_4000, 32'h0004_0000);
        end
      endcase
      program_regs(c);

      // Phase 4 bursts with no gaps against a long receiver hold-off.
      calm = (phase == 4) || ($urandom_range(0, 3) == 0);
      if (phase == 4) hold_req = 1'b1;

      // Counters carry over from the last phase; a first_of_image is rare,
      // so positions left beyond a new limit get exercised too.
      repeat (PhaseWords) begin
        if ($urandom_range(0, 99) < 15) begin
          send_load($urandom_range(0, MaxChannels - 1), pick_coef(MeanSpan),
                    pick_coef(ScaleSpan), pick_coef(ScaleSpan), pick_coef(MeanSpan));
        end else begin
          send_data($urandom, $urandom_range(0, 19) == 0);
        end
      end
      settle();
    end

    if (trk.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
